[rtl/grid_line_cell_walker_top_defines.svh]
// Assertion macros for the grid line cell walker.
// Depends on nothing; included by the top level, which supplies clk and rst.
`ifndef GRID_LINE_CELL_WALKER_TOP_DEFINES_SVH
`define GRID_LINE_CELL_WALKER_TOP_DEFINES_SVH

// Implication checked in the same cycle.
`define GCLW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication checked in the cycle after the antecedent.
`define GCLW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/gclw_pkg.sv]
// Shared types, constants and helpers for the grid line cell walker.
// Depends on nothing; used by the channel interfaces and the top level.
package gclw_pkg;

  localparam int PIX_W         = 16;
  localparam int CS_W          = 12;
  localparam int OUT_W         = 5;
  localparam int STEP_W        = CS_W + PIX_W;
  localparam int SCORE_W       = 40;
  localparam int BUDGET_W      = PIX_W + 1;
  localparam int MAX_RESULTS   = 63;
  localparam int CNT_W         = $clog2(MAX_RESULTS + 1);
  localparam int DIV_STEPS     = PIX_W;
  localparam int DIV_CNT_W     = $clog2(DIV_STEPS);
  localparam int GRID_COLS_DEF = 32;
  localparam int GRID_ROWS_DEF = 32;

  localparam logic [CS_W-1:0] CELL_SIZE_RESET = 12'd64;

  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_PLUS  = 2'd1,
    DIR_MINUS = 2'd2
  } dir_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_PREP,
    ST_WALK,
    ST_FLUSH
  } walk_state_t;

  // Operand slots of the shared divider and multiplier.
  typedef enum logic [1:0] {
    OP_X0 = 2'd0,
    OP_Y0 = 2'd1,
    OP_X1 = 2'd2,
    OP_Y1 = 2'd3
  } op_slot_t;

  function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
    logic [PIX_W-1:0] res;
    res = (a > b) ? (a - b) : (b - a);
    return res;
  endfunction

endpackage

[rtl/gclw_if.sv]
// Valid/ready channel interfaces for segment input and crossed cell output.
// Depends on gclw_pkg for the field widths.
interface gclw_in_if import gclw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] start_x;
  logic [PIX_W-1:0] start_y;
  logic [PIX_W-1:0] end_x;
  logic [PIX_W-1:0] end_y;

  modport source (output valid, output start_x, output start_y, output end_x,
                  output end_y, input ready);
  modport sink   (input valid, input start_x, input start_y, input end_x,
                  input end_y, output ready);
endinterface

interface gclw_out_if import gclw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] cell_x;
  logic [OUT_W-1:0] cell_y;
  logic             last_cell;

  modport source (output valid, output cell_x, output cell_y, output last_cell,
                  input ready);
  modport sink   (input valid, input cell_x, input cell_y, input last_cell,
                  output ready);
endinterface

[rtl/grid_line_cell_walker_top.sv]
// After a segment beat the setup runs four divisions on the shared bit-serial divider
// (start x, start y, end x, end y), four multiplies and a prep step; then the single walk step
// unit visits one cell of the walk per cycle (cells off the grid too), unless the output stalls.
// A new segment is taken only in idle, once the walk and its final flush are done.
// Reset (rst, synchronous, active high) returns to idle, empties the output register and
// sets cell_edge to 64.
`include "grid_line_cell_walker_top_defines.svh"

module grid_line_cell_walker_top
  import gclw_pkg::*;
#(
  parameter int GRID_COLS = GRID_COLS_DEF,
  parameter int GRID_ROWS = GRID_ROWS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [CS_W-1:0] cfg_wdata,
  gclw_in_if.sink         seg,
  gclw_out_if.source      cells
);

  // Widths of a saturated column and row index.
  localparam int CW = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int RW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam logic [PIX_W-1:0] COL_LIM = PIX_W'(GRID_COLS - 1);
  localparam logic [PIX_W-1:0] ROW_LIM = PIX_W'(GRID_ROWS - 1);

  // Configuration and the latched segment.
  logic [CS_W-1:0]  cell_edge;
  logic [CS_W-1:0]  cs_q;
  logic [PIX_W-1:0] sx_q, sy_q, ex_q, ey_q;
  logic [PIX_W-1:0] adx, ady;
  dir_t             dir_x, dir_y;

  walk_state_t state, state_next;

  // The shared restoring divider works one quotient bit per cycle. Four divisions are
  // run back to back: start x, start y, end x, end y, each by the cell size.
  op_slot_t             div_idx;
  logic [DIV_CNT_W-1:0] div_bit;
  logic [CS_W-1:0]      rem;
  logic [PIX_W-1:0]     dq;
  logic [PIX_W-1:0]     div_src;
  logic [PIX_W-1:0]     dq_in;
  logic [CS_W-1:0]      rem_in;
  logic [CS_W:0]        div_shift;
  logic [CS_W:0]        div_diff;
  logic                 div_ge;
  logic [CS_W-1:0]      rem_next;
  logic [PIX_W-1:0]     quo_next;
  logic                 div_last;

  // Cell coordinates as the true geometry gives them, before saturation.
  logic [PIX_W-1:0] cur_col, cur_row, fin_col, fin_row;
  logic [CS_W-1:0]  rem_x, rem_y;

  // The shared multiplier forms the two starting scores and the two score steps.
  op_slot_t          mul_idx;
  logic [CS_W-1:0]   dist_x, dist_y;
  logic [CS_W-1:0]   mul_a;
  logic [PIX_W-1:0]  mul_b;
  logic [STEP_W-1:0] mul_p;

  // Crossing scores: distance to the next boundary times the travel on the other axis,
  // so comparing them compares the crossing times exactly.
  logic [SCORE_W-1:0]  nxs, nys;
  logic [STEP_W-1:0]   x_step, y_step;
  logic [BUDGET_W-1:0] budget;

  // The newest emitted cell is held back until it is known whether it is the last one.
  logic [CNT_W-1:0] n_out;
  logic [CW-1:0]    pend_c, sat_c;
  logic [RW-1:0]    pend_r, sat_r;

  logic             out_valid;
  logic [OUT_W-1:0] out_x, out_y;
  logic             out_last;

  logic seg_beat;
  logic out_free;
  logic emit, full, at_final, step_x, step_y, stop_walk;
  logic walk_push, walk_go, flush_push;

  assign seg.ready     = (state == ST_IDLE);
  assign seg_beat      = seg.valid && seg.ready;
  assign cells.valid     = out_valid;
  assign cells.cell_x    = out_x;
  assign cells.cell_y    = out_y;
  assign cells.last_cell = out_last;

  // The output register is free when it is empty or its beat is taken in this cycle.
  assign out_free = !out_valid || cells.ready;

  // Divider step. On the first step of a division the dividend is taken straight from the
  // latched segment, so no separate load cycle is needed.
  always_comb begin
    case (div_idx)
      OP_X0:   div_src = sx_q;
      OP_Y0:   div_src = sy_q;
      OP_X1:   div_src = ex_q;
      default: div_src = ey_q;
    endcase
    dq_in     = (div_bit == '0) ? div_src : dq;
    rem_in    = (div_bit == '0) ? '0 : rem;
    div_shift = {rem_in, dq_in[PIX_W-1]};
    div_ge    = (div_shift >= {1'b0, cs_q});
    div_diff  = div_shift - {1'b0, cs_q};
    rem_next  = div_ge ? div_diff[CS_W-1:0] : div_shift[CS_W-1:0];
    quo_next  = {dq_in[PIX_W-2:0], div_ge};
    div_last  = (div_bit == DIV_CNT_W'(DIV_STEPS - 1));
  end

  // Distance from the start point to the first boundary in the direction of travel. The
  // remainder is below the cell size, so the upward distance lies between 1 and the size.
  always_comb begin
    case (dir_x)
      DIR_PLUS:  dist_x = cs_q - rem_x;
      DIR_MINUS: dist_x = rem_x;
      default:   dist_x = '0;
    endcase
    case (dir_y)
      DIR_PLUS:  dist_y = cs_q - rem_y;
      DIR_MINUS: dist_y = rem_y;
      default:   dist_y = '0;
    endcase
    case (mul_idx)
      OP_X0: begin
        mul_a = dist_x;
        mul_b = ady;
      end
      OP_Y0: begin
        mul_a = dist_y;
        mul_b = adx;
      end
      OP_X1: begin
        mul_a = cs_q;
        mul_b = ady;
      end
      default: begin
        mul_a = cs_q;
        mul_b = adx;
      end
    endcase
    mul_p = STEP_W'(mul_a) * STEP_W'(mul_b);
  end

  // One step of the walk. The current cell is saturated to the grid and emitted only if it
  // differs from the cell emitted before it. The axis whose boundary is crossed first is
  // stepped; a tie goes to y, and an axis without travel is never stepped.
  always_comb begin
    sat_c     = (cur_col > COL_LIM) ? CW'(GRID_COLS - 1) : cur_col[CW-1:0];
    sat_r     = (cur_row > ROW_LIM) ? RW'(GRID_ROWS - 1) : cur_row[RW-1:0];
    emit      = (n_out == '0) || (sat_c != pend_c) || (sat_r != pend_r);
    full      = (n_out == CNT_W'(MAX_RESULTS));
    at_final  = (cur_col == fin_col) && (cur_row == fin_row);
    step_x    = (dir_x != DIR_NONE) && ((dir_y == DIR_NONE) || (nxs < nys));
    step_y    = !step_x && (dir_y != DIR_NONE);
    stop_walk = at_final || (budget == '0) || (!step_x && !step_y);
    // A new cell pushes the held one out, so the output register has to be free.
    walk_push  = emit && !full && (n_out != '0);
    walk_go    = (state == ST_WALK) && !(emit && full) && (!walk_push || out_free);
    flush_push = (state == ST_FLUSH) && out_free;
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (seg.valid) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_last && (div_idx == OP_Y1)) state_next = ST_MUL;
      end
      ST_MUL: begin
        if (mul_idx == OP_Y1) state_next = ST_PREP;
      end
      ST_PREP: begin
        state_next = ST_WALK;
      end
      ST_WALK: begin
        // A cell beyond the limit of results ends the walk; the held cell becomes the last.
        if (emit && full) state_next = ST_FLUSH;
        else if (walk_go && stop_walk) state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_edge <= CELL_SIZE_RESET;
    end else if (cfg_we) begin
      cell_edge <= cfg_wdata;
    end
  end

  // Segment capture and the setup sequence.
  always_ff @(posedge clk) begin
    if (seg_beat) begin
      sx_q    <= seg.start_x;
      sy_q    <= seg.start_y;
      ex_q    <= seg.end_x;
      ey_q    <= seg.end_y;
      // A cell size of zero is taken as one pixel.
      cs_q    <= (cell_edge == '0) ? CS_W'(1) : cell_edge;
      adx     <= abs_diff(seg.end_x, seg.start_x);
      ady     <= abs_diff(seg.end_y, seg.start_y);
      dir_x   <= (seg.end_x > seg.start_x) ? DIR_PLUS :
                 (seg.end_x < seg.start_x) ? DIR_MINUS : DIR_NONE;
      dir_y   <= (seg.end_y > seg.start_y) ? DIR_PLUS :
                 (seg.end_y < seg.start_y) ? DIR_MINUS : DIR_NONE;
      div_idx <= OP_X0;
      div_bit <= '0;
      mul_idx <= OP_X0;
    end
    if (state == ST_DIV) begin
      rem     <= rem_next;
      dq      <= quo_next;
      div_bit <= div_bit + DIV_CNT_W'(1);
      if (div_last) begin
        case (div_idx)
          OP_X0: begin
            cur_col <= quo_next;
            rem_x   <= rem_next;
          end
          OP_Y0: begin
            cur_row <= quo_next;
            rem_y   <= rem_next;
          end
          OP_X1:   fin_col <= quo_next;
          default: fin_row <= quo_next;
        endcase
        div_idx <= op_slot_t'(div_idx + 2'd1);
      end
    end
    if (state == ST_MUL) begin
      case (mul_idx)
        OP_X0:   nxs    <= SCORE_W'(mul_p);
        OP_Y0:   nys    <= SCORE_W'(mul_p);
        OP_X1:   x_step <= mul_p;
        default: y_step <= mul_p;
      endcase
      mul_idx <= op_slot_t'(mul_idx + 2'd1);
    end
    if (state == ST_PREP) begin
      budget <= BUDGET_W'(abs_diff(fin_col, cur_col)) + BUDGET_W'(abs_diff(fin_row, cur_row));
    end
    if (walk_go) begin
      if (emit) begin
        pend_c <= sat_c;
        pend_r <= sat_r;
      end
      if (!stop_walk) begin
        budget <= budget - BUDGET_W'(1);
        if (step_x) begin
          if (dir_x == DIR_PLUS) cur_col <= cur_col + PIX_W'(1);
          else if (cur_col != '0) cur_col <= cur_col - PIX_W'(1);
          nxs <= nxs + SCORE_W'(x_step);
        end else begin
          if (dir_y == DIR_PLUS) cur_row <= cur_row + PIX_W'(1);
          else if (cur_row != '0) cur_row <= cur_row - PIX_W'(1);
          nys <= nys + SCORE_W'(y_step);
        end
      end
    end
  end

  // Count of cells emitted for the current segment, the held one included.
  always_ff @(posedge clk) begin
    if (rst) begin
      n_out <= '0;
    end else if (seg_beat) begin
      n_out <= '0;
    end else if (walk_go && emit) begin
      n_out <= n_out + CNT_W'(1);
    end
  end

  // Output register. It holds a finished beat while the walk carries on behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((walk_go && walk_push) || flush_push) begin
      out_valid <= 1'b1;
    end else if (cells.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((walk_go && walk_push) || flush_push) begin
      out_x    <= OUT_W'(pend_c);
      out_y    <= OUT_W'(pend_r);
      out_last <= flush_push;
    end
  end

  // The partial remainder of the divider stays below the cell size.
  `GCLW_ASSERT_NOW(a_div_rem_below_size, (state == ST_DIV) && (div_bit != '0), rem < cs_q, "divider remainder not below cell size")
  // A walk step moves along one axis only.
  `GCLW_ASSERT_NEXT(a_walk_one_axis, state == ST_WALK, (cur_col == $past(cur_col)) || (cur_row == $past(cur_row)), "walk moved on both axes in one step")
  // A held cell is always there to close the segment with.
  `GCLW_ASSERT_NOW(a_flush_has_cell, state == ST_FLUSH, n_out != '0, "segment closed with no cell held")

endmodule
